[hw/rtl/bida_pkg.sv]
// Shared types and constants for the bitmap ID allocator.
// No dependencies; imported by bida_core and bitmap_id_allocator_top.
`timescale 1ns / 1ps

package bida_pkg;

	localparam int ID_W             = 10;
	localparam int ID_COUNT_DEFAULT = 1024;
	localparam int BYTE_BITS        = 8;
	localparam logic [BYTE_BITS-1:0] FULL_BYTE = 8'hFF;

	typedef enum logic [0:0] {
		REQ_ALLOC = 1'b0,
		REQ_FREE  = 1'b1
	} req_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_ALLOC = 2'd2
	} status_t;

	typedef struct packed {
		logic [ID_W-1:0] id;
		status_t         status;
	} res_t;

endpackage

[hw/rtl/bida_core.sv]
// Request engine of the bitmap ID allocator: bitmap memory, clear sweep,
// byte scan and read-modify-write. Depends on bida_pkg.
`timescale 1ns / 1ps

module bida_core #(
	parameter int ID_COUNT = bida_pkg::ID_COUNT_DEFAULT
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  bida_pkg::req_t            in_req,
	input  logic [bida_pkg::ID_W-1:0] in_id,
	output logic                      res_valid,
	input  logic                      res_ready,
	output bida_pkg::res_t            res
);
	import bida_pkg::*;

	localparam int ID_BYTES = ID_COUNT / BYTE_BITS;
	localparam int ID_LIMIT = ID_BYTES * BYTE_BITS;
	localparam int BYTE_W   = (ID_BYTES > 1) ? $clog2(ID_BYTES) : 1;
	localparam int IDX_W    = BYTE_W + 3;
	localparam logic [BYTE_W-1:0] LAST_BYTE = BYTE_W'(ID_BYTES - 1);

	typedef enum logic [1:0] {
		CLEAR,
		IDLE,
		EVAL,
		RESP
	} state_t;

	state_t            state_q;
	req_t              req_q;
	logic              in_range_q;
	logic [2:0]        bit_q;
	logic [BYTE_W-1:0] cur_q;
	logic [BYTE_W-1:0] cnt_q;
	logic [BYTE_W-1:0] scan_q;
	logic [BYTE_W-1:0] clr_q;
	res_t              res_q;

	logic [BYTE_BITS-1:0] mem [ID_BYTES];
	logic [BYTE_BITS-1:0] rd_data_q;

	logic                 rd_en;
	logic [BYTE_W-1:0]    rd_addr;
	logic                 wr_en;
	logic [BYTE_W-1:0]    wr_addr;
	logic [BYTE_BITS-1:0] wr_data;

	logic                 in_range;
	logic [31:0]          in_byte_wide;
	logic [BYTE_W-1:0]    in_byte;
	logic [BYTE_W-1:0]    cur_next;
	logic                 byte_full;
	logic [2:0]           low_bit;
	logic [BYTE_BITS-1:0] low_mask;
	logic [BYTE_BITS-1:0] free_mask;
	logic                 free_hit;
	logic [IDX_W-1:0]     alloc_idx;
	logic [31:0]          alloc_wide;

	assign in_range     = 32'(in_id) < 32'(ID_LIMIT);
	assign in_byte_wide = 32'(in_id) >> 3;
	assign in_byte      = in_byte_wide[BYTE_W-1:0];
	assign cur_next     = (cur_q == LAST_BYTE) ? '0 : cur_q + 1'b1;
	assign byte_full    = rd_data_q == FULL_BYTE;

	always_comb begin
		low_bit = 3'd0;
		for (int b = BYTE_BITS - 1; b >= 0; b--) begin
			if (!rd_data_q[b]) begin
				low_bit = 3'(b);
			end
		end
	end

	assign low_mask   = 8'd1 << low_bit;
	assign free_mask  = 8'd1 << bit_q;
	assign free_hit   = in_range_q && ((rd_data_q & free_mask) != '0);
	assign alloc_idx  = {cur_q, low_bit};
	assign alloc_wide = 32'(alloc_idx);

	assign in_ready  = state_q == IDLE;
	assign res_valid = state_q == RESP;
	assign res       = res_q;

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = cur_next;
		wr_en   = 1'b0;
		wr_addr = cur_q;
		wr_data = '0;
		case (state_q)
			CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
			end
			IDLE: begin
				if (in_valid) begin
					if (in_req == REQ_FREE) begin
						rd_en   = in_range;
						rd_addr = in_byte;
					end else begin
						rd_en   = 1'b1;
						rd_addr = scan_q;
					end
				end
			end
			EVAL: begin
				if (req_q == REQ_ALLOC) begin
					if (!byte_full) begin
						wr_en   = 1'b1;
						wr_data = rd_data_q | low_mask;
					end else if (cnt_q != LAST_BYTE) begin
						rd_en = 1'b1;
					end
				end else if (free_hit) begin
					wr_en   = 1'b1;
					wr_data = rd_data_q & ~free_mask;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= CLEAR;
			req_q      <= REQ_ALLOC;
			in_range_q <= 1'b0;
			bit_q      <= '0;
			cur_q      <= '0;
			cnt_q      <= '0;
			scan_q     <= '0;
			clr_q      <= '0;
			res_q      <= '0;
		end else begin
			case (state_q)
				CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_BYTE) begin
						state_q <= IDLE;
					end
				end
				IDLE: begin
					if (in_valid) begin
						req_q      <= in_req;
						in_range_q <= in_range;
						bit_q      <= in_id[2:0];
						cnt_q      <= '0;
						cur_q      <= (in_req == REQ_FREE) ? in_byte : scan_q;
						state_q    <= EVAL;
					end
				end
				EVAL: begin
					if (req_q == REQ_ALLOC) begin
						if (!byte_full) begin
							scan_q     <= cur_q;
							res_q.id     <= alloc_wide[ID_W-1:0];
							res_q.status <= ST_OK;
							state_q    <= RESP;
						end else if (cnt_q == LAST_BYTE) begin
							res_q.id     <= '0;
							res_q.status <= ST_FULL;
							state_q    <= RESP;
						end else begin
							cur_q <= cur_next;
							cnt_q <= cnt_q + 1'b1;
						end
					end else begin
						res_q.id     <= '0;
						res_q.status <= free_hit ? ST_OK : ST_NOT_ALLOC;
						state_q      <= RESP;
					end
				end
				RESP: begin
					if (res_ready) begin
						state_q <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	a_full_gives_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.status == ST_FULL |-> res.id == '0)
		else $error("pool full result carries a non-zero ID");

	a_free_gives_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && req_q == REQ_FREE |-> res.id == '0 && res.status != ST_FULL)
		else $error("free result carries an ID or a full status");

	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == CLEAR |-> !in_ready && !rd_en)
		else $error("request taken during clear sweep");

	a_scan_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == EVAL && req_q == REQ_ALLOC && byte_full && cnt_q == LAST_BYTE
		|=> state_q == RESP && res.status == ST_FULL)
		else $error("scan ran past the last byte");

endmodule

[hw/rtl/bitmap_id_allocator_top.sv]
// Top level of the bitmap ID allocator: stream ports and output register.
// Depends on bida_pkg and bida_core.
// Flow: a word is accepted in IDLE; EVAL then checks one byte for a free or scans
// for an alloc (k full bytes skipped, at most ID_COUNT/8 - 1; one memory read per
// cycle); RESP then hands the result on. A new request is taken only in IDLE.
// Reset: arst_n clears control state; the bitmap is then swept to zero, one byte
// per cycle over all ID_COUNT/8 bytes, with s_tready held low throughout.
`timescale 1ns / 1ps

module bitmap_id_allocator_top #(
	parameter int ID_COUNT = bida_pkg::ID_COUNT_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // [9:0] id_to_free, [15:10] zero
	input  logic [0:0]  s_tuser,  // [0] req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata   // [9:0] id_given, [11:10] status, [15:12] zero
);
	import bida_pkg::*;

	logic        res_valid;
	logic        res_ready;
	res_t        res;
	logic        m_tvalid_q;
	logic [15:0] m_tdata_q;

	bida_core #(
		.ID_COUNT(ID_COUNT)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_req   (req_t'(s_tuser[0])),
		.in_id    (s_tdata[ID_W-1:0]),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
		end else if (res_ready) begin
			m_tvalid_q <= res_valid;
			if (res_valid) begin
				m_tdata_q <= {4'b0000, res.status, res.id};
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule
